// ===== sv/gauss_jordan_matrix_inverse_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_DEFINES_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define GJI_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define GJI_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/gji_pkg.sv =====
// ----------------------------------------------------------------------------
// gji_pkg
// Types and constants of the Gauss-Jordan inverter.
// ----------------------------------------------------------------------------
package gji_pkg;
  localparam int MaxOrder = 8;
  localparam int Cells = MaxOrder * MaxOrder;
  localparam int IdxW = $clog2(Cells);
  localparam int RcW = $clog2(MaxOrder);
  localparam logic signed [31:0] QOne = 32'sd65536;
  localparam logic [3:0] SizeReset = 4'd4;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [RcW-1:0] rc_t;

  typedef enum logic [12:0] {
    ST_LOAD  = 13'b0000000000001,
    ST_INIT  = 13'b0000000000010,
    ST_SRCH  = 13'b0000000000100,
    ST_SWAP  = 13'b0000000001000,
    ST_PIV   = 13'b0000000010000,
    ST_NRD   = 13'b0000000100000,
    ST_NDIV  = 13'b0000001000000,
    ST_FACT  = 13'b0000010000000,
    ST_ERD   = 13'b0000100000000,
    ST_EMUL  = 13'b0001000000000,
    ST_EWR   = 13'b0010000000000,
    ST_OUT   = 13'b0100000000000,
    ST_SING  = 13'b1000000000000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== sv/gauss_jordan_matrix_inverse.sv =====
// Sequence: n*n loads, setting up the identity, then per pivot a search, a
// swap, 2n divisions on a 48-step serial divider and the elimination (two
// products per element pair, in the two phases of ST_EMUL), 2n^2 divisions in
// all, then n*n outputs.
// Throughput: one matrix at a time; busy is high from the last load until
// the last result. Results cannot be stalled. Reset clears control state only.
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse
// Gauss-Jordan inverse with partial pivoting, signed Q16.16, saturating.
// ----------------------------------------------------------------------------
`include "gauss_jordan_matrix_inverse_defines.svh"
module gauss_jordan_matrix_inverse import gji_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value_i,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  output logic               result_valid_o,
  output logic signed [31:0] inverse_value_o,
  output logic               singular_o,
  output logic               last_of_run_o
);
  logic signed [31:0] wm [Cells];
  logic signed [31:0] im [Cells];
  logic [3:0] size_q;
  logic [3:0] n;
  state_e state_q;
  logic [6:0] cnt_q;
  rc_t p_q, r_q, c_q, best_q;
  logic signed [32:0] best_abs_q;
  logic signed [31:0] wa_q, ia_q, piv_q, f_q, wr_q, ir_q, wp_q, ip_q;
  logic signed [65:0] prw_q, pri_q;
  logic ph_q;
  // serial divider
  logic [5:0] dcnt_q;
  logic [63:0] drem_q;
  logic [63:0] dquo_q;
  logic [31:0] dden_q;
  logic dneg_q;
  logic dsel_q;
  logic signed [31:0] div_res;

  assign n = (size_q == 4'd0) ? 4'd1 : ((size_q > 4'(MaxOrder)) ? 4'(MaxOrder) : size_q);
  logic [6:0] total;
  assign total = 7'(n) * 7'(n);
  function automatic idx_t ix(input rc_t r, input rc_t c, input logic [3:0] nn);
    return idx_t'(7'(r) * 7'(nn) + 7'(c));
  endfunction
  rc_t nm1;
  assign nm1 = rc_t'(n - 4'd1);

  assign busy = (state_q != ST_LOAD);

  logic signed [32:0] cabs;
  assign cabs = wa_q[31] ? -33'(wa_q) : 33'(wa_q);

  logic [64:0] dtrial;
  assign dtrial = {drem_q, dquo_q[63]} - {33'd0, dden_q};
  assign div_res = sat32(dneg_q ? -66'(dquo_q) : 66'(dquo_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; size_q <= SizeReset; cnt_q <= '0;
      result_valid_o <= 1'b0; dcnt_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin size_q <= cfg_wdata_i; cnt_q <= '0; end
      case (state_q)
        ST_LOAD: if (start && !cfg_we_i) begin
          wm[idx_t'(cnt_q)] <= element_value_i;
          if (cnt_q + 7'd1 >= total) begin
            cnt_q <= '0; r_q <= '0; c_q <= '0; p_q <= '0; state_q <= ST_INIT;
          end else cnt_q <= cnt_q + 7'd1;
        end
        ST_INIT: begin
          im[ix(r_q, c_q, n)] <= (r_q == c_q) ? QOne : 32'sd0;
          if (c_q == nm1) begin
            c_q <= '0;
            if (r_q == nm1) begin
              r_q <= '0; ph_q <= 1'b0; state_q <= ST_SRCH;
            end else r_q <= r_q + 1'b1;
          end else c_q <= c_q + 1'b1;
        end
        ST_SRCH: begin
          // phase 0 reads, phase 1 compares
          if (!ph_q) begin
            if (r_q < p_q) r_q <= p_q;
            else begin wa_q <= wm[ix(r_q, p_q, n)]; ph_q <= 1'b1; end
          end else begin
            ph_q <= 1'b0;
            if (r_q == p_q || cabs > best_abs_q) begin
              best_q <= r_q; best_abs_q <= cabs;
            end
            if (r_q == nm1) begin c_q <= '0; state_q <= ST_SWAP; end
            else r_q <= r_q + 1'b1;
          end
        end
        ST_SWAP: begin
          if (best_q == p_q) state_q <= ST_PIV;
          else if (!ph_q) begin
            wa_q <= wm[ix(p_q, c_q, n)]; ia_q <= im[ix(p_q, c_q, n)];
            wr_q <= wm[ix(best_q, c_q, n)]; ir_q <= im[ix(best_q, c_q, n)];
            ph_q <= 1'b1;
          end else begin
            wm[ix(p_q, c_q, n)] <= wr_q; im[ix(p_q, c_q, n)] <= ir_q;
            wm[ix(best_q, c_q, n)] <= wa_q; im[ix(best_q, c_q, n)] <= ia_q;
            ph_q <= 1'b0;
            if (c_q == nm1) state_q <= ST_PIV; else c_q <= c_q + 1'b1;
          end
        end
        ST_PIV: begin
          if (!ph_q) begin piv_q <= wm[ix(p_q, p_q, n)]; ph_q <= 1'b1; end
          else begin
            ph_q <= 1'b0; c_q <= '0; dsel_q <= 1'b0;
            state_q <= (piv_q == 32'sd0) ? ST_SING : ST_NRD;
          end
        end
        ST_NRD: begin
          if (!ph_q) begin
            wa_q <= dsel_q ? im[ix(p_q, c_q, n)] : wm[ix(p_q, c_q, n)];
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            dneg_q <= wa_q[31] ^ piv_q[31];
            // dividend |a| * 2^16 sits in the top 48 bits
            dquo_q <= {(wa_q[31] ? 32'(-wa_q) : 32'(wa_q)), 32'd0};
            drem_q <= '0;
            dden_q <= piv_q[31] ? 32'(-piv_q) : 32'(piv_q);
            dcnt_q <= 6'd48;
            state_q <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          if (dcnt_q != 6'd0) begin
            dcnt_q <= dcnt_q - 6'd1;
            if (!dtrial[64]) begin
              drem_q <= dtrial[63:0]; dquo_q <= {dquo_q[62:0], 1'b1};
            end else begin
              drem_q <= {drem_q[62:0], dquo_q[63]}; dquo_q <= {dquo_q[62:0], 1'b0};
            end
          end else begin
            if (dsel_q) im[ix(p_q, c_q, n)] <= div_res;
            else wm[ix(p_q, c_q, n)] <= div_res;
            if (!dsel_q) dsel_q <= 1'b1;
            else begin
              dsel_q <= 1'b0;
              if (c_q == nm1) begin
                r_q <= '0; state_q <= ST_FACT;
              end else c_q <= c_q + 1'b1;
            end
            if (!(dsel_q && c_q == nm1)) state_q <= ST_NRD;
          end
        end
        ST_FACT: begin
          if (r_q == p_q) begin
            if (r_q == nm1) begin
              if (p_q == nm1) begin cnt_q <= '0; state_q <= ST_OUT; end
              else begin p_q <= p_q + 1'b1; r_q <= '0; ph_q <= 1'b0; state_q <= ST_SRCH; end
            end else r_q <= r_q + 1'b1;
          end else begin
            f_q <= wm[ix(r_q, p_q, n)]; c_q <= '0; state_q <= ST_ERD;
          end
        end
        ST_ERD: begin
          wr_q <= wm[ix(r_q, c_q, n)]; ir_q <= im[ix(r_q, c_q, n)];
          wp_q <= wm[ix(p_q, c_q, n)]; ip_q <= im[ix(p_q, c_q, n)];
          ph_q <= 1'b0; state_q <= ST_EMUL;
        end
        ST_EMUL: begin
          // two multiply phases: work column then inverse column
          if (!ph_q) begin prw_q <= 66'(f_q * wp_q); ph_q <= 1'b1; end
          else begin pri_q <= 66'(f_q * ip_q); state_q <= ST_EWR; end
        end
        ST_EWR: begin
          wm[ix(r_q, c_q, n)] <= sat32(66'(wr_q) - 66'(sat32(prw_q / 66'sd65536)));
          im[ix(r_q, c_q, n)] <= sat32(66'(ir_q) - 66'(sat32(pri_q / 66'sd65536)));
          if (c_q == nm1) begin
            if (r_q == nm1) begin
              if (p_q == nm1) begin cnt_q <= '0; state_q <= ST_OUT; end
              else begin p_q <= p_q + 1'b1; r_q <= '0; ph_q <= 1'b0; state_q <= ST_SRCH; end
            end else begin r_q <= r_q + 1'b1; state_q <= ST_FACT; end
          end else begin c_q <= c_q + 1'b1; state_q <= ST_ERD; end
        end
        ST_OUT: begin
          result_valid_o <= 1'b1;
          inverse_value_o <= im[idx_t'(cnt_q)];
          singular_o <= 1'b0;
          last_of_run_o <= (cnt_q + 7'd1 == total);
          if (cnt_q + 7'd1 == total) begin cnt_q <= '0; state_q <= ST_LOAD; end
          else cnt_q <= cnt_q + 7'd1;
        end
        ST_SING: begin
          result_valid_o <= 1'b1; inverse_value_o <= '0;
          singular_o <= 1'b1; last_of_run_o <= 1'b1;
          cnt_q <= '0; state_q <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  `GJI_ASSERT_NXT(a_sing_last, state_q == ST_SING, result_valid_o && last_of_run_o)
  `GJI_ASSERT_IMP(a_sing_zero, result_valid_o && singular_o, inverse_value_o == 32'sd0)
  `GJI_ASSERT_IMP(a_no_load_busy, state_q == ST_LOAD, !busy)
  `GJI_ASSERT_IMP(a_last_idle, result_valid_o && last_of_run_o, !busy)
endmodule

// ===== test/tb_gauss_jordan_matrix_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauss_jordan_matrix_inverse
// Loads matrices of every order through the start/busy port, predicts each
// inverse with a Q16.16 Gauss-Jordan model kept here, and checks every result
// in order. A directed table covers extremes, pivot swaps, singular matrices,
// out-of-range orders and an abandoned load; random matrices follow.
// ----------------------------------------------------------------------------
module tb_gauss_jordan_matrix_inverse;
  import gji_pkg::*;

  typedef enum logic [0:0] {ROW_SIZE, ROW_ELEM} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] value;
    bit          typed;      // expectation given below instead of predicted
    logic [31:0] exp_value;
    bit          exp_sing;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic               sing;
    logic               last;
  } inv_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] element_value_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [3:0]         cfg_wdata_i = '0;
  logic               result_valid_o;
  logic signed [31:0] inverse_value_o;
  logic               singular_o;
  logic               last_of_run_o;

  gauss_jordan_matrix_inverse dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .inverse_value_o(inverse_value_o),
    .singular_o     (singular_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL gauss_jordan_matrix_inverse");
    $finish;
  end

  // ---------------- predictor ----------------
  int          mat_a [Cells];
  int          mat_inv [Cells];
  int          loaded;
  logic [3:0]  size_reg;
  inv_result_t inverse_q[$];
  int          mismatches;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int order_of(logic [3:0] s);
    if (s == 0) return 1;
    if (s > MaxOrder) return MaxOrder;
    return int'(s);
  endfunction

  function automatic int qmul(int a, int b);
    return clip32((longint'(a) * longint'(b)) / 65536);
  endfunction

  function automatic int qdiv(int a, int d);
    return clip32((longint'(a) * 65536) / longint'(d));
  endfunction

  function automatic longint mag(int v);
    return v < 0 ? -longint'(v) : longint'(v);
  endfunction

  function automatic bit eliminate(int n);
    int best, piv, f, t;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) mat_inv[r*n+c] = (r == c) ? QOne : 0;
    for (int p = 0; p < n; p++) begin
      best = p;
      for (int r = p; r < n; r++)
        if (mag(mat_a[r*n+p]) > mag(mat_a[best*n+p])) best = r;
      if (best != p) begin
        for (int c = 0; c < n; c++) begin
          t = mat_a[p*n+c]; mat_a[p*n+c] = mat_a[best*n+c]; mat_a[best*n+c] = t;
          t = mat_inv[p*n+c]; mat_inv[p*n+c] = mat_inv[best*n+c];
          mat_inv[best*n+c] = t;
        end
      end
      piv = mat_a[p*n+p];
      if (piv == 0) return 1'b0;
      for (int c = 0; c < n; c++) begin
        mat_a[p*n+c] = qdiv(mat_a[p*n+c], piv);
        mat_inv[p*n+c] = qdiv(mat_inv[p*n+c], piv);
      end
      for (int r = 0; r < n; r++) begin
        if (r == p) continue;
        f = mat_a[r*n+p];
        for (int c = 0; c < n; c++) begin
          mat_a[r*n+c] = clip32(longint'(mat_a[r*n+c]) - qmul(f, mat_a[p*n+c]));
          mat_inv[r*n+c] = clip32(longint'(mat_inv[r*n+c]) - qmul(f, mat_inv[p*n+c]));
        end
      end
    end
    return 1'b1;
  endfunction

  // Returns the number of results queued for this element.
  function automatic int predict_element(logic [31:0] v);
    int n, total;
    inv_result_t res;
    n = order_of(size_reg);
    total = n * n;
    if (loaded >= total) loaded = 0;
    mat_a[loaded] = int'(v);
    loaded++;
    if (loaded < total) return 0;
    loaded = 0;
    if (!eliminate(n)) begin
      res.value = '0; res.sing = 1'b1; res.last = 1'b1;
      inverse_q.push_back(res);
      return 1;
    end
    for (int k = 0; k < total; k++) begin
      res.value = mat_inv[k]; res.sing = 1'b0; res.last = (k == total - 1);
      inverse_q.push_back(res);
    end
    return total;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    inv_result_t want;
    if (rst_ni && result_valid_o) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%0d sing=%0b last=%0b",
                   inverse_value_o, singular_o, last_of_run_o);
      end else begin
        want = inverse_q.pop_front();
        if (inverse_value_o !== want.value || singular_o !== want.sing ||
            last_of_run_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%0d sing=%0b last=%0b, got %0d %0b %0b",
                     want.value, want.sing, want.last,
                     inverse_value_o, singular_o, last_of_run_o);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  int  burst_left;
  bit  gaps_on;
  int  sent;

  // Holds start until the transfer; start stays high unless a gap follows.
  task automatic send_element(logic [31:0] v, output int produced);
    start <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (busy);
    produced = predict_element(v);
    sent++;
    if (gaps_on && --burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic write_size(logic [3:0] s);
    start <= 1'b0;
    @(posedge clk_i);
    while (inverse_q.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = s;
    loaded = 0;
  endtask

  stim_row_t table_rows[$] = '{
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},   // partial load at order 4
    '{ROW_SIZE, 32'd1,         1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
    '{ROW_ELEM, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
    '{ROW_ELEM, 32'h8000_0000, 1'b1, 32'hffff_fffe, 1'b0},
    '{ROW_ELEM, 32'h7fff_ffff, 1'b1, 32'h0000_0002, 1'b0},
    '{ROW_ELEM, 32'h0000_0001, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_ELEM, 32'hffff_ffff, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_SIZE, 32'd0,         1'b0, 32'h0, 1'b0},    // order 0 acts as 1
    '{ROW_ELEM, 32'h0002_0000, 1'b1, 32'h0000_8000, 1'b0},
    '{ROW_SIZE, 32'd2,         1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0000_0000, 1'b0, 32'h0, 1'b0},    // needs a row swap
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0001_0000, 1'b0, 32'h0, 1'b0},    // rank one
    '{ROW_ELEM, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'h0004_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_SIZE, 32'd15,        1'b0, 32'h0, 1'b0},    // clamps to max order
    '{ROW_ELEM, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
    '{ROW_ELEM, 32'hdead_beef, 1'b0, 32'h0, 1'b0},
    '{ROW_SIZE, 32'd1,         1'b0, 32'h0, 1'b0},    // drops the partial load
    '{ROW_ELEM, 32'h0003_0000, 1'b0, 32'h0, 1'b0}
  };

  function automatic logic [31:0] rand_entry(int mode, bit diag);
    case (mode)
      0: return $urandom();
      1: return diag ? $urandom_range(32'h0002_0000, 32'h0008_0000)
                     : 32'($signed($urandom_range(0, 32'h0001_0000)) - 32'sh8000);
      default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  initial begin
    int produced, n, mode, dup;
    logic [31:0] vals [Cells];
    logic [3:0] s;
    inv_result_t typed_res;
    size_reg = SizeReset;
    loaded = 0;
    mismatches = 0;
    sent = 0;
    gaps_on = 1'b0;
    burst_left = 4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_SIZE) begin
        write_size(table_rows[i].value[3:0]);
      end else begin
        send_element(table_rows[i].value, produced);
        if (table_rows[i].typed && produced == 1) begin
          void'(inverse_q.pop_back());
          typed_res.value = table_rows[i].exp_value;
          typed_res.sing = table_rows[i].exp_sing;
          typed_res.last = 1'b1;
          inverse_q.push_back(typed_res);
        end
      end
    end

    while (sent < 300) begin
      case ($urandom_range(0, 19))
        0:       s = 4'd0;
        1:       s = 4'($urandom_range(9, 15));
        2, 3:    s = 4'($urandom_range(5, 8));
        default: s = 4'($urandom_range(1, 4));
      endcase
      if ($urandom_range(0, 3) != 0 || s != size_reg) write_size(s);
      n = order_of(s);
      mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      gaps_on = $urandom_range(0, 3) != 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) vals[r*n+c] = rand_entry(mode, r == c);
      dup = $urandom_range(0, 5);
      if (n >= 2 && dup == 0)
        for (int c = 0; c < n; c++) vals[n+c] = vals[c];
      else if (dup == 1)
        for (int r = 0; r < n; r++) vals[r*n+n-1] = '0;
      for (int k = 0; k < n * n; k++) send_element(vals[k], produced);
    end

    start <= 1'b0;
    for (int w = 0; w < 200_000 && inverse_q.size() != 0; w++) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("PASS gauss_jordan_matrix_inverse");
    end else begin
      $display("FAIL gauss_jordan_matrix_inverse");
    end
    $finish;
  end
endmodule
